// ===== rtl/core/tsr_pkg.sv =====
// Shared types for the triangle span rasterizer: controller states and the
// command and status bundles between controller and datapath.
// No dependencies.
package tsr_pkg;

   localparam int ROW_BITS    = 6;
   localparam int COLOUR_BITS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIV_START,
      ST_DIV,
      ST_SETUP_TOP,
      ST_SETUP_BOT,
      ST_EMIT,
      ST_ADV
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic setup_top;
      logic setup_bot;
      logic adv_start;
      logic adv_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic flat_top;
      logic flat_bot;
      logic div_busy;
      logic adv_busy;
      logic out_free;
      logic at_end;
      logic span_last;
   } sts_type;

endpackage

// ===== rtl/core/triangle_span_rasterizer.sv =====
// Top level of the triangle span rasterizer: stream ports, field packing,
// controller and datapath. Depends on tsr_pkg, tsr_ctrl, tsr_datapath.
//
// Usage: one request on req_* carries a triangle (three vertices and a
// colour). The block answers with one response per covered row on rsp_*,
// from the lowest y to the highest, tlast set on the final span.
// req_tready is high only while no triangle is in work; a new request may be
// taken while the final span still waits in the output register.
// A flat-top or flat-bottom triangle goes from classification straight to
// half setup and its first span; any other triangle first runs the
// split-point divider, one quotient bit per cycle over COORD_BITS+9 bits.
// Between spans both edges advance in parallel; a shallow edge steps x
// until its error turns non-negative, and the slower edge sets the pace.
// When the receiver stalls, the controller holds before loading the next
// span; nothing is dropped. Reset clears the controller, the divider
// counter, the edge busy flags, the span counter and the output valid.
module triangle_span_rasterizer #(
   parameter int FRAME_ROWS = 64,
   parameter int COORD_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, b_x, b_y, c_x, c_y, fill_colour, zero pad
   input  logic [((3*COORD_BITS+26+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // span_row, span_x_left, span_x_right, span_colour, zero pad
   output logic [((2*COORD_BITS+14+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import tsr_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int RB   = ROW_BITS;
   localparam int OW   = 2*CB + RB + COLOUR_BITS;
   localparam int OUTW = ((2*COORD_BITS+14+7)/8)*8;

   cmd_type cmd;
   sts_type sts;

   logic [RB-1:0]          out_row;
   logic [CB-1:0]          out_xl, out_xr;
   logic [COLOUR_BITS-1:0] out_colour;

   tsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tsr_datapath #(
      .FRAME_ROWS (FRAME_ROWS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_ax      (req_tdata[CB-1:0]),
      .in_ay      (req_tdata[CB+RB-1:CB]),
      .in_bx      (req_tdata[2*CB+RB-1:CB+RB]),
      .in_by      (req_tdata[2*CB+2*RB-1:2*CB+RB]),
      .in_cx      (req_tdata[3*CB+2*RB-1:2*CB+2*RB]),
      .in_cy      (req_tdata[3*CB+3*RB-1:3*CB+2*RB]),
      .in_colour  (req_tdata[3*CB+3*RB+COLOUR_BITS-1:3*CB+3*RB]),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_row    (out_row),
      .out_xl     (out_xl),
      .out_xr     (out_xr),
      .out_colour (out_colour),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(OUTW-OW){1'b0}}, out_colour, out_xr, out_xl, out_row};

   // a span is only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("span loaded over a pending response");

   // one triangle in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a triangle is in work");

   // the final span of a triangle frees the request side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid && rsp_tlast) |-> req_tready)
      else $error("final span shown while controller still busy");

endmodule

// ===== rtl/core/tsr_ctrl.sv =====
// Sequencer for the span rasterizer: classify, split-point division, half
// setup, edge advance and span emission. Depends on tsr_pkg.
module tsr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tsr_pkg::sts_type sts,
   output tsr_pkg::cmd_type cmd
);
   import tsr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            priority if (sts.flat_top) begin
               state_in = ST_SETUP_TOP;
            end else if (sts.flat_bot) begin
               state_in = ST_SETUP_BOT;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = ST_SETUP_TOP;
            end
         end
         ST_SETUP_TOP: begin
            cmd.setup_top = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_SETUP_BOT: begin
            cmd.setup_bot = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               priority if (sts.span_last) begin
                  state_in = ST_IDLE;
               end else if (sts.at_end) begin
                  // end of the lower half of a split triangle
                  state_in = ST_SETUP_BOT;
               end else begin
                  cmd.adv_start = 1'b1;
                  state_in      = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            if (sts.adv_busy) begin
               cmd.adv_step = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/tsr_datapath.sv =====
// Datapath of the span rasterizer: vertex sort, split-point divider, two
// Bresenham edge trackers, row counters and the output register.
// Depends on tsr_pkg.
module tsr_datapath #(
   parameter int FRAME_ROWS = 64,
   parameter int COORD_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tsr_pkg::cmd_type                  cmd,
   output tsr_pkg::sts_type                  sts,
   input  logic [COORD_BITS-1:0]             in_ax,
   input  logic [tsr_pkg::ROW_BITS-1:0]      in_ay,
   input  logic [COORD_BITS-1:0]             in_bx,
   input  logic [tsr_pkg::ROW_BITS-1:0]      in_by,
   input  logic [COORD_BITS-1:0]             in_cx,
   input  logic [tsr_pkg::ROW_BITS-1:0]      in_cy,
   input  logic [tsr_pkg::COLOUR_BITS-1:0]   in_colour,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [tsr_pkg::ROW_BITS-1:0]      out_row,
   output logic [COORD_BITS-1:0]             out_xl,
   output logic [COORD_BITS-1:0]             out_xr,
   output logic [tsr_pkg::COLOUR_BITS-1:0]   out_colour,
   output logic                              out_last
);
   import tsr_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int EW   = CB + 4;                // edge error width, signed
   localparam int NW   = CB + ROW_BITS + 3;     // split numerator width
   localparam int SW   = NW + 1;
   localparam int DCW  = $clog2(NW + 1);
   localparam int CNTW = $clog2(FRAME_ROWS);

   typedef struct packed {
      logic [CB-1:0]        x;
      logic signed [EW-1:0] err;
      logic signed [EW-1:0] plain;
      logic signed [EW-1:0] step;
      logic                 left;
      logic                 steep;
   } edge_type;

   function automatic edge_type setup_edge(input logic [CB-1:0] sx,
                                           input logic [ROW_BITS-1:0] sy,
                                           input logic [CB-1:0] ex,
                                           input logic [ROW_BITS-1:0] ey);
      edge_type             r;
      logic signed [EW-1:0] dxs, dys, adx;
      dxs     = $signed({{(EW-CB){1'b0}}, ex}) - $signed({{(EW-CB){1'b0}}, sx});
      dys     = $signed({{(EW-ROW_BITS){1'b0}}, ey})
              - $signed({{(EW-ROW_BITS){1'b0}}, sy});
      r.left  = !(dxs > 0);
      adx     = r.left ? -dxs : dxs;
      r.steep = !(adx > dys);
      if (!r.steep) begin
         r.plain = dys + dys;
         r.step  = r.plain - adx - adx;
         r.err   = r.plain - adx;
      end else begin
         r.plain = adx + adx;
         r.step  = r.plain - dys - dys;
         r.err   = r.plain - dys;
      end
      r.x = sx;
      return r;
   endfunction

   function automatic logic [CB-1:0] move_x(input logic [CB-1:0] x, input logic left);
      return left ? x - 1'b1 : x + 1'b1;
   endfunction

   // sorted vertices: index 0 highest y, 2 lowest y
   logic [CB-1:0]       vx_ff [3];
   logic [ROW_BITS-1:0] vy_ff [3];
   logic [CB-1:0]       vx_in [3];
   logic [ROW_BITS-1:0] vy_in [3];
   logic [COLOUR_BITS-1:0] colour_ff;

   edge_type            edge_ff [2];
   logic [1:0]          busy_ff;
   logic [ROW_BITS-1:0] row_now_ff, row_end_ff;
   logic                final_ff;
   logic [CNTW-1:0]     cnt_ff;

   logic [NW-1:0]       dvd_ff;
   logic [ROW_BITS:0]   rem_ff;
   logic [ROW_BITS:0]   dsr_ff;
   logic [DCW-1:0]      dcnt_ff;

   logic                out_valid_ff, out_last_ff;
   logic [ROW_BITS-1:0] out_row_ff;
   logic [CB-1:0]       out_xl_ff, out_xr_ff;
   logic [COLOUR_BITS-1:0] out_colour_ff;

   logic                general;
   logic [CB-1:0]       q_x;

   // three compare-and-swap stages on the incoming vertices
   always_comb begin
      logic [CB-1:0]       tx;
      logic [ROW_BITS-1:0] ty;
      tx = '0;
      ty = '0;
      vx_in[0] = in_ax; vy_in[0] = in_ay;
      vx_in[1] = in_bx; vy_in[1] = in_by;
      vx_in[2] = in_cx; vy_in[2] = in_cy;
      if (vy_in[0] < vy_in[2]) begin
         tx = vx_in[0]; ty = vy_in[0];
         vx_in[0] = vx_in[2]; vy_in[0] = vy_in[2];
         vx_in[2] = tx; vy_in[2] = ty;
      end
      if (vy_in[0] < vy_in[1]) begin
         tx = vx_in[0]; ty = vy_in[0];
         vx_in[0] = vx_in[1]; vy_in[0] = vy_in[1];
         vx_in[1] = tx; vy_in[1] = ty;
      end
      if (vy_in[1] < vy_in[2]) begin
         tx = vx_in[1]; ty = vy_in[1];
         vx_in[1] = vx_in[2]; vy_in[1] = vy_in[2];
         vx_in[2] = tx; vy_in[2] = ty;
      end
   end

   assign sts.flat_top = (vy_ff[0] == vy_ff[1]);
   assign sts.flat_bot = !sts.flat_top && (vy_ff[1] == vy_ff[2]);
   assign general      = !sts.flat_top && !sts.flat_bot;
   assign q_x          = dvd_ff[CB-1:0];

   // split numerator: 2*x0*m + 2*(x2-x0)*n + m, always non-negative
   logic signed [SW-1:0] x0e, x2e, me, ne, num;
   always_comb begin
      x0e = $signed({{(SW-CB){1'b0}}, vx_ff[0]});
      x2e = $signed({{(SW-CB){1'b0}}, vx_ff[2]});
      me  = $signed({{(SW-ROW_BITS){1'b0}}, vy_ff[0] - vy_ff[2]});
      ne  = $signed({{(SW-ROW_BITS){1'b0}}, vy_ff[0] - vy_ff[1]});
      num = x0e * me * SW'(2) + (x2e - x0e) * ne * SW'(2) + me;
   end

   logic [ROW_BITS+1:0] trial;
   logic                geq;
   assign trial = {rem_ff, dvd_ff[NW-1]};
   assign geq   = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= DCW'(NW);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= num[NW-1:0];
         rem_ff <= '0;
         dsr_ff <= {vy_ff[0] - vy_ff[2], 1'b0};
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[NW-2:0], geq};
         rem_ff <= geq ? (ROW_BITS+1)'(trial - {1'b0, dsr_ff}) : trial[ROW_BITS:0];
      end
   end
   assign sts.div_busy = (dcnt_ff != '0);

   // half setup: edge start/end points
   logic [CB-1:0]       t0x, t1x, a_sx, a_ex, b_sx, b_ex;
   logic [ROW_BITS-1:0] s_y, e_y;
   edge_type            a_set, b_set;
   always_comb begin
      if (cmd.setup_bot) begin
         t0x  = vx_ff[1];
         t1x  = general ? q_x : vx_ff[2];
         s_y  = general ? vy_ff[1] + 1'b1 : vy_ff[2];
         e_y  = vy_ff[0];
         a_sx = (t1x < t0x) ? t1x : t0x;
         b_sx = (t1x < t0x) ? t0x : t1x;
         a_ex = vx_ff[0];
         b_ex = vx_ff[0];
      end else begin
         t0x  = general ? q_x : vx_ff[0];
         t1x  = vx_ff[1];
         s_y  = vy_ff[2];
         e_y  = vy_ff[1];
         a_sx = vx_ff[2];
         b_sx = vx_ff[2];
         a_ex = (t0x < t1x) ? t0x : t1x;
         b_ex = (t0x < t1x) ? t1x : t0x;
      end
      a_set = setup_edge(a_sx, s_y, a_ex, e_y);
      b_set = setup_edge(b_sx, s_y, b_ex, e_y);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= vx_in[i];
            vy_ff[i] <= vy_in[i];
         end
         colour_ff <= in_colour;
      end
      if (cmd.setup_top || cmd.setup_bot) begin
         edge_ff[0] <= a_set;
         edge_ff[1] <= b_set;
         row_now_ff <= s_y;
         row_end_ff <= e_y;
         final_ff   <= cmd.setup_bot || !general;
      end else if (cmd.adv_start) begin
         row_now_ff <= row_now_ff + 1'b1;
      end else if (cmd.adv_step) begin
         for (int k = 0; k < 2; k++) begin
            if (busy_ff[k]) begin
               if (edge_ff[k].steep) begin
                  if (edge_ff[k].err >= 0) begin
                     edge_ff[k].x   <= move_x(edge_ff[k].x, edge_ff[k].left);
                     edge_ff[k].err <= edge_ff[k].err + edge_ff[k].step;
                  end else begin
                     edge_ff[k].err <= edge_ff[k].err + edge_ff[k].plain;
                  end
               end else begin
                  edge_ff[k].x <= move_x(edge_ff[k].x, edge_ff[k].left);
                  if (edge_ff[k].err >= 0) begin
                     edge_ff[k].err <= edge_ff[k].err + edge_ff[k].step;
                  end else begin
                     edge_ff[k].err <= edge_ff[k].err + edge_ff[k].plain;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (cmd.adv_start) begin
         busy_ff <= 2'b11;
      end else if (cmd.adv_step) begin
         for (int k = 0; k < 2; k++) begin
            // a shallow edge stays busy until its error turns non-negative
            if (edge_ff[k].steep || edge_ff[k].err >= 0) begin
               busy_ff[k] <= 1'b0;
            end
         end
      end
   end
   assign sts.adv_busy = |busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign sts.at_end    = (row_now_ff == row_end_ff);
   assign sts.span_last = (final_ff && sts.at_end) || (cnt_ff == CNTW'(FRAME_ROWS - 1));
   assign sts.out_free  = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_row_ff    <= row_now_ff;
         out_xl_ff     <= edge_ff[0].x;
         out_xr_ff     <= edge_ff[1].x;
         out_colour_ff <= colour_ff;
         out_last_ff   <= sts.span_last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_row    = out_row_ff;
   assign out_xl     = out_xl_ff;
   assign out_xr     = out_xr_ff;
   assign out_colour = out_colour_ff;
   assign out_last   = out_last_ff;

endmodule
